FILE: rtl/core/breakpoint_table_lookup_defines.svh
// ----------------------------------------------------------------------------
// Breakpoint table lookup assertion macros
// Shared concurrent assertion macros; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_TABLE_LOOKUP_DEFINES_SVH
`define BREAKPOINT_TABLE_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS

`define BTL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

`define BTL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define BTL_ASSERT_IMP(name, clk, rst_n, ante, cons)

`define BTL_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/bts_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint table lookup package
// Request kinds, outcome codes and fixed-width payload types.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ENABLE = 2'd1;
  localparam logic [1:0] KIND_CHECK  = 2'd2;

  localparam logic [1:0] OUT_RUN   = 2'd0;
  localparam logic [1:0] OUT_BREAK = 2'd1;
  localparam logic [1:0] OUT_STALE = 2'd2;

  localparam int unsigned COUNT_W = 7;

  typedef struct packed {
    logic sys_thread;
    logic in_breakpoint;
    logic stepping;
  } flags_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [7:0] opcode_out;
    logic [5:0] match_index;
  } result_t;

endpackage

FILE: rtl/core/bts_req_if.sv
// ----------------------------------------------------------------------------
// Breakpoint table request channel
// Valid/ready channel that carries one load, enable or check request.
// ----------------------------------------------------------------------------
interface bts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  entry_index;
  logic [15:0] method_id;
  logic [15:0] code_offset;
  logic [7:0]  saved_opcode;
  logic        enable_flag;
  logic        thread_is_system;
  logic        thread_in_breakpoint;
  logic        thread_stepping;

  modport source (
    output valid, kind, entry_index, method_id, code_offset, saved_opcode,
           enable_flag, thread_is_system, thread_in_breakpoint, thread_stepping,
    input  ready
  );

  modport sink (
    input  valid, kind, entry_index, method_id, code_offset, saved_opcode,
           enable_flag, thread_is_system, thread_in_breakpoint, thread_stepping,
    output ready
  );
endinterface

FILE: rtl/core/bts_rsp_if.sv
// ----------------------------------------------------------------------------
// Breakpoint table result channel
// Valid/ready channel that carries the outcome of one check request.
// ----------------------------------------------------------------------------
interface bts_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic [7:0] opcode_out;
  logic [5:0] match_index;

  modport source (
    output valid, outcome, opcode_out, match_index,
    input  ready
  );

  modport sink (
    input  valid, outcome, opcode_out, match_index,
    output ready
  );
endinterface

FILE: rtl/core/breakpoint_table_lookup.sv
// ----------------------------------------------------------------------------
// Breakpoint table lookup
// Sorted breakpoint table with a chained binary search over its entries.
// ----------------------------------------------------------------------------
// The req channel carries load, enable and check requests; rsp carries one
// result for each check request. The user must write entry_count through
// cfg_we_i and cfg_wdata_i only while the block is idle; it is not enforced.
// Load and enable requests write the table RAM when they are taken;
// they give no result, and a request of kind three is dropped.
// A check request runs through a row of $clog2(MAX_ENTRIES+1) search cells,
// one probe each, every probe reading the table RAM through its single read
// port. The result passes from the seed register through the cell registers
// into the result register, and no new request is taken while a check is
// in flight, so checks do not overlap.
// A spare result register holds a finished check while the receiver stalls,
// so one more check may be taken and completed before req.ready drops.
// Reset clears the handshake state and entry_count; the table RAM is not
// cleared, and each entry must be loaded before a check can probe it.
// ----------------------------------------------------------------------------
`include "breakpoint_table_lookup_defines.svh"

module breakpoint_table_lookup #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned ID_BITS     = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bts_req_if.sink                      req,
  bts_rsp_if.source                    rsp,
  input  logic                         cfg_we_i,
  input  logic [bts_pkg::COUNT_W-1:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned MW = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int unsigned KW = MW + 16 + 8;
  localparam int unsigned NCELL = CW;

  typedef struct packed {
    logic [MW-1:0] meth;
    logic [15:0]   offs;
    logic [7:0]    opcode;
    logic          en;
  } entry_t;

  typedef struct packed {
    logic             valid;
    logic             done;
    logic             found;
    logic [CW-1:0]    low;
    logic [CW-1:0]    hiex;
    logic [AW-1:0]    mid;
    logic [MW-1:0]    meth;
    logic [15:0]      offs;
    bts_pkg::flags_t  flags;
  } state_t;

  logic                        accept;
  logic                        is_check;
  logic                        is_load;
  logic                        is_enable;
  logic [31:0]                 slot_w;
  logic                        slot_ok;
  logic [AW-1:0]               waddr;
  logic [bts_pkg::COUNT_W-1:0] count_q;
  logic [CW-1:0]               cnt_w;
  state_t                      seed_d;
  state_t                      seed_q;
  state_t                      stage [NCELL+1];
  logic [AW-1:0]               cell_addr [NCELL+1];
  logic                        cell_en [NCELL+1];
  logic [AW-1:0]               raddr;
  logic [KW-1:0]               key_rdata;
  logic [0:0]                  en_rdata;
  entry_t                      ent;
  state_t                      fin;
  bts_pkg::result_t            fin_res;
  bts_pkg::result_t            out_q;
  bts_pkg::result_t            pend_q;
  logic                        out_valid_q;
  logic                        pend_valid_q;
  logic                        busy_q;
  logic                        out_free;

  assign accept    = req.valid && req.ready;
  assign is_check  = (req.kind == bts_pkg::KIND_CHECK);
  assign is_load   = (req.kind == bts_pkg::KIND_LOAD);
  assign is_enable = (req.kind == bts_pkg::KIND_ENABLE);
  assign slot_w    = 32'(req.entry_index);
  assign slot_ok   = (slot_w < MAX_ENTRIES);
  assign waddr     = AW'(slot_w);
  assign req.ready = !busy_q && !pend_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  assign cnt_w = (32'(count_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(count_q);

  always_comb begin
    seed_d                     = '0;
    seed_d.valid               = accept && is_check;
    seed_d.done                = (cnt_w == '0);
    seed_d.hiex                = cnt_w;
    seed_d.mid                 = AW'((SW'(cnt_w) - SW'(1)) >> 1);
    seed_d.meth                = MW'(req.method_id);
    seed_d.offs                = req.code_offset;
    seed_d.flags.sys_thread    = req.thread_is_system;
    seed_d.flags.in_breakpoint = req.thread_in_breakpoint;
    seed_d.flags.stepping      = req.thread_stepping;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else begin
      seed_q <= seed_d;
    end
  end

  assign stage[0]     = seed_q;
  assign cell_addr[0] = seed_d.mid;
  assign cell_en[0]   = seed_d.valid;

  for (genvar k = 1; k <= NCELL; k++) begin : g_cell
    bts_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .state_t     (state_t),
      .entry_t     (entry_t)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .prev_i    (stage[k-1]),
      .ent_i     (ent),
      .state_o   (stage[k]),
      .rd_addr_o (cell_addr[k]),
      .rd_en_o   (cell_en[k])
    );
  end

  always_comb begin
    raddr = '0;
    for (int i = 0; i <= NCELL; i++) begin
      if (cell_en[i]) begin
        raddr = raddr | cell_addr[i];
      end
    end
  end

  bts_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (KW)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_load && slot_ok),
    .waddr_i (waddr),
    .wdata_i ({MW'(req.method_id), req.code_offset, req.saved_opcode}),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  bts_ram #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (1)
  ) u_en_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (is_load || is_enable) && slot_ok),
    .waddr_i (waddr),
    .wdata_i (req.enable_flag),
    .raddr_i (raddr),
    .rdata_o (en_rdata)
  );

  assign ent = {key_rdata, en_rdata};
  assign fin = stage[NCELL];

  always_comb begin
    fin_res = '0;
    fin_res.outcome = bts_pkg::OUT_STALE;
    if (fin.found) begin
      fin_res.opcode_out  = ent.opcode;
      fin_res.match_index = 6'(fin.mid);
      if (fin.flags.sys_thread || fin.flags.in_breakpoint || fin.flags.stepping || !ent.en) begin
        fin_res.outcome = bts_pkg::OUT_RUN;
      end else begin
        fin_res.outcome = bts_pkg::OUT_BREAK;
      end
    end
  end

  assign out_free = !out_valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (accept && is_check) begin
        busy_q <= 1'b1;
      end else if (fin.valid) begin
        busy_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= pend_valid_q || fin.valid;
      end
      if (pend_valid_q && out_free) begin
        pend_valid_q <= 1'b0;
      end else if (fin.valid && !out_free) begin
        pend_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_valid_q && out_free) begin
      out_q <= pend_q;
    end else if (fin.valid && out_free) begin
      out_q <= fin_res;
    end
    if (fin.valid && !out_free) begin
      pend_q <= fin_res;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.outcome     = out_q.outcome;
  assign rsp.opcode_out  = out_q.opcode_out;
  assign rsp.match_index = out_q.match_index;

  `BTL_ASSERT_IMP(a_fin_no_pend, clk_i, rst_ni, fin.valid, !pend_valid_q)
  `BTL_ASSERT_IMP(a_fin_busy, clk_i, rst_ni, fin.valid, busy_q)
  `BTL_ASSERT_NXT(a_check_busy, clk_i, rst_ni, accept && is_check, busy_q && !req.ready)
  `BTL_ASSERT_IMP(a_pend_out, clk_i, rst_ni, pend_valid_q, out_valid_q)

endmodule

FILE: rtl/core/bts_ram.sv
// ----------------------------------------------------------------------------
// Breakpoint table RAM
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bts_cell.sv
// ----------------------------------------------------------------------------
// Breakpoint search cell
// One probe of the binary search: compares the fetched entry with the key,
// narrows the bounds, issues the next probe address and hands on its state.
// ----------------------------------------------------------------------------
`include "breakpoint_table_lookup_defines.svh"

module bts_cell #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter type         state_t     = logic,
  parameter type         entry_t     = logic
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  state_t                         prev_i,
  input  entry_t                         ent_i,
  output state_t                         state_o,
  output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr_o,
  output logic                           rd_en_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = CW + 1;

  state_t        state_d;
  state_t        state_q;
  logic [CW-1:0] low_n;
  logic [CW-1:0] hiex_n;
  logic [SW-1:0] mid_sum;
  logic          key_eq;
  logic          key_lt;

  assign key_eq = (ent_i.meth == prev_i.meth) && (ent_i.offs == prev_i.offs);
  assign key_lt = (ent_i.meth < prev_i.meth) ||
                  ((ent_i.meth == prev_i.meth) && (ent_i.offs < prev_i.offs));

  always_comb begin
    state_d = prev_i;
    low_n   = prev_i.low;
    hiex_n  = prev_i.hiex;
    mid_sum = '0;
    if (prev_i.valid && !prev_i.done) begin
      if (key_eq) begin
        state_d.found = 1'b1;
        state_d.done  = 1'b1;
      end else begin
        if (key_lt) begin
          low_n = CW'(prev_i.mid) + CW'(1);
        end else begin
          hiex_n = CW'(prev_i.mid);
        end
        mid_sum      = SW'(low_n) + SW'(hiex_n) - SW'(1);
        state_d.low  = low_n;
        state_d.hiex = hiex_n;
        state_d.done = (low_n >= hiex_n);
        state_d.mid  = AW'(mid_sum >> 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o   = state_q;
  assign rd_addr_o = state_d.mid;
  assign rd_en_o   = state_d.valid;

  `BTL_ASSERT_NXT(a_done_sticks, clk_i, rst_ni, prev_i.valid && prev_i.done, state_q.done)
  `BTL_ASSERT_IMP(a_found_is_done, clk_i, rst_ni, state_q.valid && state_q.found, state_q.done)

endmodule

FILE: dv/breakpoint_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint table lookup scoreboard
// Keeps a shadow copy of the breakpoint table and entry_count, predicts the
// outcome of every accepted check request and compares results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

package breakpoint_scoreboard_pkg;

  localparam logic [1:0] KIND_IGNORED = 2'd3;
  localparam int unsigned TABLE_DEPTH = 64;

  typedef struct packed {
    logic [1:0]      kind;
    logic [5:0]      entry_index;
    logic [15:0]     method_id;
    logic [15:0]     code_offset;
    logic [7:0]      saved_opcode;
    logic            enable_flag;
    bts_pkg::flags_t flags;
  } bp_request_t;

  class breakpoint_scoreboard;
    logic [15:0] slot_method [TABLE_DEPTH];
    logic [15:0] slot_offset [TABLE_DEPTH];
    logic [7:0]  slot_opcode [TABLE_DEPTH];
    logic        slot_enabled [TABLE_DEPTH];
    logic [bts_pkg::COUNT_W-1:0] entry_count;
    bts_pkg::result_t pending_outcomes[$];
    int unsigned failures;

    function new();
      entry_count = '0;
      failures = 0;
    endfunction

    function void set_entry_count(logic [bts_pkg::COUNT_W-1:0] value);
      entry_count = value;
    endfunction

    function bts_pkg::result_t lookup_breakpoint(logic [15:0] method_id,
                                                 logic [15:0] code_offset,
                                                 bts_pkg::flags_t flags);
      int lo;
      int hi;
      int mid;
      bit hit;
      logic [31:0] probe_key;
      logic [31:0] slot_key;
      bts_pkg::result_t res;
      lo = 0;
      hi = ((entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count)) - 1;
      hit = 1'b0;
      mid = 0;
      probe_key = {method_id, code_offset};
      res.outcome = bts_pkg::OUT_STALE;
      res.opcode_out = '0;
      res.match_index = '0;
      while (!hit && lo <= hi) begin
        mid = (lo + hi) / 2;
        slot_key = {slot_method[mid], slot_offset[mid]};
        if (slot_key < probe_key) begin
          lo = mid + 1;
        end else if (slot_key > probe_key) begin
          hi = mid - 1;
        end else begin
          hit = 1'b1;
        end
      end
      if (hit) begin
        if (flags.sys_thread || flags.in_breakpoint || flags.stepping || !slot_enabled[mid]) begin
          res.outcome = bts_pkg::OUT_RUN;
        end else begin
          res.outcome = bts_pkg::OUT_BREAK;
        end
        res.opcode_out = slot_opcode[mid];
        res.match_index = mid[5:0];
      end
      return res;
    endfunction

    function void note_request(bp_request_t r);
      case (r.kind)
        bts_pkg::KIND_LOAD: begin
          slot_method[r.entry_index] = r.method_id;
          slot_offset[r.entry_index] = r.code_offset;
          slot_opcode[r.entry_index] = r.saved_opcode;
          slot_enabled[r.entry_index] = r.enable_flag;
        end
        bts_pkg::KIND_ENABLE: begin
          slot_enabled[r.entry_index] = r.enable_flag;
        end
        bts_pkg::KIND_CHECK: begin
          pending_outcomes.push_back(lookup_breakpoint(r.method_id, r.code_offset, r.flags));
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(bts_pkg::result_t got);
      bts_pkg::result_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result with no check pending: outcome %0d, opcode_out %0d, match_index %0d",
               got.outcome, got.opcode_out, got.match_index);
        failures++;
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("outcome", 8'(want.outcome), 8'(got.outcome));
      compare_field("opcode_out", want.opcode_out, got.opcode_out);
      compare_field("match_index", 8'(want.match_index), 8'(got.match_index));
    endfunction
  endclass

endpackage

FILE: dv/breakpoint_table_lookup_tb.sv
// ----------------------------------------------------------------------------
// Breakpoint table lookup testbench
// Loads breakpoint tables of many sizes, most of them sorted, sets entry_count across its
// range and sends load, enable and check requests with random flow control
// on both channels. Every result is checked against a shadow table search.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module breakpoint_table_lookup_tb;

  localparam int unsigned ITEM_TARGET     = 1850;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned CW              = bts_pkg::COUNT_W;
  localparam int unsigned TABLE_DEPTH     = breakpoint_scoreboard_pkg::TABLE_DEPTH;
  localparam int unsigned REQ_W           = $bits(breakpoint_scoreboard_pkg::bp_request_t);

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we;
  logic [CW-1:0] cfg_wdata;

  bts_req_if req_ch ();
  bts_rsp_if rsp_ch ();

  breakpoint_scoreboard_pkg::breakpoint_scoreboard sb;
  int unsigned burst_left;
  int unsigned items_sent;
  int unsigned cycle_count;

  breakpoint_table_lookup u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned mode_left;
    int unsigned run_left;
    int unsigned stall_mode;
    rsp_ch.ready = 1'b0;
    mode_left = 0;
    run_left = 0;
    stall_mode = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (stall_mode)
        0: rsp_ch.ready = 1'b1;
        1: rsp_ch.ready = 1'($urandom_range(0, 1));
        2: rsp_ch.ready = ($urandom_range(0, 3) == 0);
        default: begin
          if (run_left == 0) begin
            rsp_ch.ready = ~rsp_ch.ready;
            run_left = $urandom_range(1, 24);
          end else begin
            run_left--;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : result_monitor
    bts_pkg::result_t got;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.outcome, rsp_ch.opcode_out, rsp_ch.match_index};
      sb.check_result(got);
    end
  end

  function automatic breakpoint_scoreboard_pkg::bp_request_t random_request(logic [1:0] kind);
    breakpoint_scoreboard_pkg::bp_request_t r;
    r = breakpoint_scoreboard_pkg::bp_request_t'(REQ_W'({$urandom, $urandom}));
    r.kind = kind;
    return r;
  endfunction

  function automatic breakpoint_scoreboard_pkg::bp_request_t make_request(
      logic [1:0] kind, logic [5:0] entry_index, logic [15:0] method_id,
      logic [15:0] code_offset, logic [7:0] saved_opcode, logic enable_flag,
      logic [2:0] flags);
    breakpoint_scoreboard_pkg::bp_request_t r;
    r.kind = kind;
    r.entry_index = entry_index;
    r.method_id = method_id;
    r.code_offset = code_offset;
    r.saved_opcode = saved_opcode;
    r.enable_flag = enable_flag;
    r.flags = bts_pkg::flags_t'(flags);
    return r;
  endfunction

  task automatic push_request(input breakpoint_scoreboard_pkg::bp_request_t r);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
    end
    req_ch.kind = r.kind;
    req_ch.entry_index = r.entry_index;
    req_ch.method_id = r.method_id;
    req_ch.code_offset = r.code_offset;
    req_ch.saved_opcode = r.saved_opcode;
    req_ch.enable_flag = r.enable_flag;
    req_ch.thread_is_system = r.flags.sys_thread;
    req_ch.thread_in_breakpoint = r.flags.in_breakpoint;
    req_ch.thread_stepping = r.flags.stepping;
    req_ch.valid = 1'b1;
    forever begin
      @(posedge clk_i);
      if (req_ch.ready) break;
    end
    sb.note_request(r);
    burst_left--;
    if (r.kind != breakpoint_scoreboard_pkg::KIND_IGNORED) items_sent++;
  endtask

  task automatic drain_requests();
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (sb.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entry_count(input logic [CW-1:0] value);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk_i);
    sb.set_entry_count(value);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic run_phase(input int unsigned table_size, input logic [CW-1:0] count_value,
                           input bit sorted);
    logic [31:0] keys[$];
    int unsigned slots[$];
    breakpoint_scoreboard_pkg::bp_request_t r;
    int unsigned span;
    int unsigned roll;
    int unsigned s;
    bit narrow;
    narrow = 1'($urandom_range(0, 1));
    for (int unsigned i = 0; i < table_size; i++) begin
      if (narrow) begin
        keys.push_back({16'($urandom_range(0, 3)), 16'($urandom_range(0, 31))});
      end else begin
        keys.push_back($urandom);
      end
      slots.push_back(i);
    end
    if (sorted) keys.sort();
    slots.shuffle();
    foreach (slots[i]) begin
      r = random_request(bts_pkg::KIND_LOAD);
      r.entry_index = 6'(slots[i]);
      {r.method_id, r.code_offset} = keys[slots[i]];
      push_request(r);
    end
    drain_requests();
    write_entry_count(count_value);
    span = (32'(count_value) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(count_value);
    repeat (ITEMS_PER_PHASE) begin
      roll = $urandom_range(0, 99);
      r = random_request(bts_pkg::KIND_CHECK);
      if (roll < 65) begin
        if (span > 0 && $urandom_range(0, 9) < 6) begin
          s = $urandom_range(0, span - 1);
          r.method_id = sb.slot_method[s];
          r.code_offset = sb.slot_offset[s];
          if ($urandom_range(0, 4) == 0) begin
            r.code_offset = r.code_offset + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
          end
        end else if (span > 0 && $urandom_range(0, 2) == 0) begin
          r.method_id = sb.slot_method[$urandom_range(0, span - 1)];
        end
      end else if (roll < 80) begin
        r.kind = bts_pkg::KIND_ENABLE;
        if (span > 0 && $urandom_range(0, 9) < 6) begin
          r.entry_index = 6'($urandom_range(0, span - 1));
        end
      end else if (roll < 92) begin
        r.kind = bts_pkg::KIND_LOAD;
        if (span > 0 && $urandom_range(0, 1) == 1) begin
          s = $urandom_range(0, span - 1);
          r.entry_index = 6'(s);
          r.method_id = sb.slot_method[s];
          r.code_offset = sb.slot_offset[s];
        end
      end else begin
        r.kind = breakpoint_scoreboard_pkg::KIND_IGNORED;
      end
      push_request(r);
    end
    drain_requests();
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned size;
    logic [CW-1:0] count_value;
    sb = new();
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.kind = bts_pkg::KIND_LOAD;
    req_ch.entry_index = '0;
    req_ch.method_id = '0;
    req_ch.code_offset = '0;
    req_ch.saved_opcode = '0;
    req_ch.enable_flag = 1'b0;
    req_ch.thread_is_system = 1'b0;
    req_ch.thread_in_breakpoint = 1'b0;
    req_ch.thread_stepping = 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    write_entry_count('0);
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'h0000, 16'h0000, 8'h00, 1'b1,
                              3'b000));
    push_request(make_request(breakpoint_scoreboard_pkg::KIND_IGNORED, 6'd63, 16'hFFFF,
                              16'hFFFF, 8'hFF, 1'b1, 3'b111));
    push_request(make_request(bts_pkg::KIND_LOAD, 6'd0, 16'h0000, 16'h0000, 8'h00, 1'b1,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_LOAD, 6'd1, 16'h1234, 16'h0005, 8'hA5, 1'b1,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_LOAD, 6'd2, 16'h1234, 16'h0006, 8'h5A, 1'b0,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_LOAD, 6'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
                              3'b000));
    drain_requests();
    write_entry_count(7'd4);
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'h0000, 16'h0000, 8'h00, 1'b0,
                              3'b100));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'h1234, 16'h0005, 8'h00, 1'b0,
                              3'b010));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'hFFFF, 16'hFFFF, 8'h00, 1'b0,
                              3'b001));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'h1234, 16'h0006, 8'h00, 1'b0,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_ENABLE, 6'd2, 16'h0000, 16'h0000, 8'h00, 1'b1,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'h1234, 16'h0006, 8'h00, 1'b0,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_ENABLE, 6'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0,
                              3'b111));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'h0000, 16'h0000, 8'h00, 1'b0,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd63, 16'h1234, 16'h0007, 8'hFF, 1'b1,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'hFFFF, 16'hFFFE, 8'h00, 1'b0,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'h0000, 16'h0001, 8'h00, 1'b0,
                              3'b000));
    push_request(make_request(bts_pkg::KIND_CHECK, 6'd0, 16'h1234, 16'h0005, 8'h00, 1'b0,
                              3'b111));
    drain_requests();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: run_phase(64, 7'd127, 1'b1);
        1: run_phase(64, 7'd64, 1'b1);
        2: run_phase(5, 7'd0, 1'b1);
        3: run_phase(1, 7'd1, 1'b1);
        default: begin
          size = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
          count_value = CW'(size);
          if (size == TABLE_DEPTH && $urandom_range(0, 1) == 1) begin
            count_value = CW'($urandom_range(65, 127));
          end else if ($urandom_range(0, 5) == 0) begin
            count_value = CW'($urandom_range(0, size));
          end
          run_phase(size, count_value, $urandom_range(0, 7) != 0);
        end
      endcase
      phase++;
    end
    drain_requests();

    if (sb.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
